// File: rtl/chse_pkg.sv
// Shared types and constants for the cubic Hermite spline evaluator.
// No dependencies.
package chse_pkg;

   localparam int DATA_W = 32;
   localparam int MAX_NODES = 64;
   localparam int CMD_LOAD = 0;
   localparam int CMD_EVAL = 1;

   // Datapath operations requested by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RANGE_RD,
      OP_RANGE_CHK,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_PAIR_RD,
      OP_PAIR_LATCH,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL_STEP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] mul_step;
   } dp_cmd_type;

   typedef struct packed {
      logic outside;
      logic found;
      logic scan_last;
      logic div_done;
   } dp_status_type;

endpackage

// File: rtl/chse_datapath.sv
// Datapath of the spline evaluator: node memories, interval scan, serial
// divider, and a sequenced multiplier for the basis terms. Uses chse_pkg.
module chse_datapath
   import chse_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [6:0]                node_count,
   input  logic [5:0]                in_index,
   input  logic signed [DATA_W-1:0]  in_position,
   input  logic signed [DATA_W-1:0]  in_value,
   input  logic signed [DATA_W-1:0]  in_slope,
   output logic signed [DATA_W-1:0]  res_value,
   output logic                      res_outside,
   output logic                      res_saturated
);
   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = AW + 1;
   localparam int DW = DATA_W + FRAC_BITS;   // dividend width
   localparam int QCNT_W = $clog2(DW + 1);
   localparam int MW = DATA_W + 2;           // multiplier operand width
   localparam logic [CW-1:0] MAXN = CW'(MAX_NODES);

   logic signed [DATA_W-1:0] pos_mem [MAX_NODES];
   logic signed [DATA_W-1:0] val_mem [MAX_NODES];
   logic signed [DATA_W-1:0] slp_mem [MAX_NODES];

   logic [AW-1:0] rd_addr;
   logic signed [DATA_W-1:0] rd_pos_ff, rd_val_ff, rd_slp_ff;

   logic [CW-1:0] n_eff;
   logic [CW-1:0] idx_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] left_ff;
   logic signed [DATA_W:0]   h_ff;
   logic signed [DATA_W-1:0] v0_ff, s0_ff, v1_ff, s1_ff;
   logic outside_ff, found_ff, first_ff;

   // Divider state.
   logic [DW-1:0]     dvd_ff;
   logic [DATA_W:0]   rem_ff;
   logic [DW-1:0]     quo_ff;
   logic [QCNT_W-1:0] dcnt_ff;
   logic              tzero_ff;

   // Basis terms and accumulator.
   logic signed [FRAC_BITS+1:0] t_ff, t2_ff, t3_ff;
   logic signed [MW-1:0] b10_ff, b11_ff;
   logic signed [DATA_W+FRAC_BITS+8:0] acc_ff;
   logic signed [DATA_W:0]   sum_out;

   // Effective node count clamped to [2, MAX_NODES].
   always_comb begin
      n_eff = CW'(node_count);
      if (node_count < 7'd2) n_eff = CW'(2);
      if ({25'd0, node_count} > 32'(MAX_NODES)) n_eff = MAXN;
   end

   // Memory read address by operation.
   always_comb begin
      case (cmd.op)
         OP_RANGE_RD:  rd_addr = '0;
         OP_RANGE_CHK: rd_addr = AW'(n_eff - CW'(1));
         OP_SCAN_RD:   rd_addr = AW'(idx_ff);
         OP_PAIR_RD:   rd_addr = first_ff ? AW'(idx_ff - CW'(1)) : AW'(idx_ff);
         default:      rd_addr = '0;
      endcase
   end

   // Node memories.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && {26'd0, in_index} < 32'(MAX_NODES)) begin
         pos_mem[AW'(in_index)] <= in_position;
         val_mem[AW'(in_index)] <= in_value;
         slp_mem[AW'(in_index)] <= in_slope;
      end
      rd_pos_ff <= pos_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
      rd_slp_ff <= slp_mem[rd_addr];
   end

   // Divider remainder trial.
   logic [DATA_W+1:0] trial;
   logic [DATA_W:0]   rem_sh;
   always_comb begin
      rem_sh = {rem_ff[DATA_W-1:0], dvd_ff[DW-1]};
      trial  = {1'b0, rem_sh} - {1'b0, h_ff[DATA_W:0]};
   end

   // Multiplier sequence: one product per step.
   logic signed [MW-1:0] ma, mb;
   logic signed [2*MW-1:0] prod;
   logic signed [DATA_W+FRAC_BITS+4:0] prod_sh;
   logic signed [FRAC_BITS+3:0] one_s;
   always_comb begin
      one_s = (FRAC_BITS+4)'(1) <<< FRAC_BITS;
      ma = '0;
      mb = '0;
      case (cmd.mul_step)
         5'd0: begin ma = t_ff;  mb = t_ff;  end
         5'd1: begin ma = t2_ff; mb = t_ff;  end
         5'd2: begin ma = t_ff - 2*t2_ff + t3_ff; mb = h_ff; end
         5'd3: begin ma = t3_ff - t2_ff; mb = h_ff; end
         5'd4: begin ma = v0_ff; mb = one_s - 3*t2_ff + 2*t3_ff; end
         5'd5: begin ma = s0_ff; mb = b10_ff; end
         5'd6: begin ma = v1_ff; mb = 3*t2_ff - 2*t3_ff; end
         5'd7: begin ma = s1_ff; mb = b11_ff; end
         default: ;
      endcase
      prod    = (2*MW)'(ma) * (2*MW)'(mb);
      prod_sh = (DATA_W+FRAC_BITS+5)'(prod >>> FRAC_BITS);
   end

   // Main datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= 1'b1;
         outside_ff <= 1'b0;
         found_ff   <= 1'b0;
         idx_ff     <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               outside_ff <= 1'b0;
               acc_ff     <= '0;
               first_ff   <= 1'b1;
            end
            OP_RANGE_RD: begin
               // The query is only on the input in the transfer cycle.
               if (first_ff) x_ff <= in_position;
               first_ff <= 1'b0;
               outside_ff <= 1'b0;
               acc_ff   <= '0;
               idx_ff   <= '0;
            end
            OP_RANGE_CHK: begin
               // The first check sees node 0, the second the last node in use.
               if (idx_ff == '0) begin
                  if (x_ff < rd_pos_ff) outside_ff <= 1'b1;
               end else begin
                  if (x_ff > rd_pos_ff) outside_ff <= 1'b1;
                  first_ff <= 1'b1;
               end
               idx_ff <= CW'(1);
            end
            OP_SCAN_RD: found_ff <= 1'b0;
            OP_SCAN_CHK: begin
               if (x_ff < rd_pos_ff || idx_ff == n_eff - CW'(1)) found_ff <= 1'b1;
               else idx_ff <= idx_ff + CW'(1);
            end
            OP_PAIR_RD: begin
               // The second read cycle sees the left node of the interval.
               if (!first_ff) begin
                  left_ff <= rd_pos_ff;
                  v0_ff   <= rd_val_ff;
                  s0_ff   <= rd_slp_ff;
               end
               first_ff <= ~first_ff;
            end
            OP_PAIR_LATCH: begin
               h_ff  <= (DATA_W+1)'(rd_pos_ff) - (DATA_W+1)'(left_ff);
               v1_ff <= rd_val_ff;
               s1_ff <= rd_slp_ff;
            end
            OP_DIV_INIT: begin
               tzero_ff <= (h_ff <= 0) || (x_ff <= left_ff);
               dvd_ff   <= DW'((DATA_W+1)'(x_ff) - (DATA_W+1)'(left_ff)) << FRAC_BITS;
               rem_ff   <= '0;
               quo_ff   <= '0;
               dcnt_ff  <= QCNT_W'(DW);
            end
            OP_DIV_STEP: begin
               dvd_ff <= dvd_ff << 1;
               if (!trial[DATA_W+1]) begin
                  rem_ff <= trial[DATA_W:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - QCNT_W'(1);
               if (dcnt_ff == QCNT_W'(1)) begin
                  if (tzero_ff) t_ff <= '0;
                  else if (quo_ff[DW-2:FRAC_BITS-1] != '0)
                     t_ff <= (FRAC_BITS+2)'(1) <<< FRAC_BITS;
                  else t_ff <= (FRAC_BITS+2)'({quo_ff[FRAC_BITS-1:0],
                                               ~trial[DATA_W+1]});
                  idx_ff <= '0;
               end
            end
            OP_MUL_STEP: begin
               case (cmd.mul_step)
                  5'd0: t2_ff <= (FRAC_BITS+2)'(prod_sh);
                  5'd1: t3_ff <= (FRAC_BITS+2)'(prod_sh);
                  5'd2: b10_ff <= MW'(prod_sh);
                  5'd3: b11_ff <= MW'(prod_sh);
                  default: acc_ff <= acc_ff + (DATA_W+FRAC_BITS+9)'(prod_sh);
               endcase
            end
            default: ;
         endcase
      end
   end

   // Saturation of the accumulated sum.
   always_comb begin
      res_saturated = 1'b0;
      sum_out = '0;
      if (acc_ff > (DATA_W+FRAC_BITS+9)'(32'sh7FFFFFFF)) begin
         res_value = 32'sh7FFFFFFF;
         res_saturated = 1'b1;
      end else if (acc_ff < -(DATA_W+FRAC_BITS+9)'(33'sh080000000)) begin
         res_value = 32'sh80000000;
         res_saturated = 1'b1;
      end else begin
         sum_out = (DATA_W+1)'(acc_ff);
         res_value = sum_out[DATA_W-1:0];
      end
      if (outside_ff) begin
         res_value = '0;
         res_saturated = 1'b0;
      end
   end

   assign res_outside = outside_ff;
   assign status.outside   = outside_ff;
   assign status.found     = found_ff;
   assign status.scan_last = 1'b0;
   assign status.div_done  = (dcnt_ff == QCNT_W'(1));

endmodule

// File: rtl/chse_ctrl.sv
// Controller state machine of the spline evaluator: sequences range check,
// interval scan, division and multiplies. Uses chse_pkg.
module chse_ctrl
   import chse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          load_rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_RANGE_A, S_RANGE_B, S_RANGE_C, S_RANGE_D, S_SCAN_RD, S_SCAN_CHK,
      S_PAIR_A, S_PAIR_B, S_PAIR_C, S_PAIR_D, S_DIV_INIT, S_DIV, S_MUL, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       valid_ff, valid_in, load_ff, load_in;
   logic       take;

   assign req_stall = (state_ff != S_IDLE) || valid_ff;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = valid_ff;
   assign load_rsp  = load_ff;

   // Command decode and next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && rsp_stall;
      load_in  = load_ff;
      cmd.op   = OP_NONE;
      cmd.mul_step = step_ff;
      case (state_ff)
         S_IDLE: if (take) begin
            if (req_cmd == 1'(CMD_LOAD)) begin
               cmd.op = OP_LOAD; load_in = 1'b1; state_in = S_DONE;
            end else begin
               cmd.op = OP_RANGE_RD; load_in = 1'b0; state_in = S_RANGE_A;
            end
         end
         S_RANGE_A: begin cmd.op = OP_RANGE_RD; state_in = S_RANGE_B; end
         S_RANGE_B: begin cmd.op = OP_RANGE_CHK; state_in = S_RANGE_C; end
         S_RANGE_C: begin cmd.op = OP_RANGE_CHK; state_in = S_RANGE_D; end
         S_RANGE_D: state_in = status.outside ? S_DONE : S_SCAN_RD;
         S_SCAN_RD: begin cmd.op = OP_SCAN_RD; state_in = S_SCAN_CHK; end
         S_SCAN_CHK: begin
            cmd.op = OP_SCAN_CHK; state_in = S_PAIR_A;
         end
         S_PAIR_A: state_in = status.found ? S_PAIR_B : S_SCAN_RD;
         S_PAIR_B: begin cmd.op = OP_PAIR_RD; state_in = S_PAIR_C; end
         S_PAIR_C: begin cmd.op = OP_PAIR_RD; state_in = S_PAIR_D; end
         S_PAIR_D: begin cmd.op = OP_PAIR_LATCH; state_in = S_DIV_INIT; end
         S_DIV_INIT: begin cmd.op = OP_DIV_INIT; state_in = S_DIV; end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_done) begin state_in = S_MUL; step_in = '0; end
         end
         S_MUL: begin
            cmd.op = OP_MUL_STEP; step_in = step_ff + 5'd1;
            if (step_ff == 5'd7) state_in = S_DONE;
         end
         S_DONE: begin valid_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
         load_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
         load_ff  <= load_in;
      end
   end
endmodule

// File: rtl/cubic_hermite_spline_eval_top.sv
// Top level of the cubic Hermite spline evaluator: node_count register,
// controller and datapath. Uses chse_pkg, chse_ctrl and chse_datapath.
//
// Usage: req_ carries one item; cmd 0 loads node entry node_index with
// position, value and slope; cmd 1 evaluates the spline at position.
// An item transfers when req_valid is high and req_stall low; a result
// transfers on rsp_valid high and rsp_stall low. csr_wr_en writes node_count.
// A load result becomes valid after its transfer through S_DONE and the
// registered rsp_valid. An evaluate outside the node span passes the states
// S_RANGE_A to S_RANGE_D and S_DONE. Inside the span it adds a linear node
// scan that visits one node at a time up to the interval index k, the pair
// reads, the serial divider and the multiply steps. One item is in work at a
// time, and the next item can transfer once the result has transferred and
// rsp_valid has dropped. Reset clears the controller and sets node_count to 2;
// node tables are undefined until loaded. While rsp_stall is high the result
// holds and no new item is taken.
module cubic_hermite_spline_eval_top
   import chse_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [5:0]               req_node_index,
   input  logic signed [DATA_W-1:0] req_position,
   input  logic signed [DATA_W-1:0] req_value_coef,
   input  logic signed [DATA_W-1:0] req_slope_coef,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_spline_value,
   output logic                     rsp_outside,
   output logic                     rsp_saturated,
   input  logic                     csr_wr_en,
   input  logic [6:0]               csr_wr_data
);
   logic [6:0] node_count_ff;
   dp_cmd_type cmd;
   dp_status_type status;
   logic load_rsp;
   logic signed [DATA_W-1:0] dp_value;
   logic dp_outside, dp_sat;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= 7'd2;
      else if (csr_wr_en) node_count_ff <= csr_wr_data;
   end

   chse_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .rsp_valid, .rsp_stall,
      .status, .cmd, .load_rsp
   );

   chse_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .status, .node_count(node_count_ff),
      .in_index(req_node_index), .in_position(req_position),
      .in_value(req_value_coef), .in_slope(req_slope_coef),
      .res_value(dp_value), .res_outside(dp_outside), .res_saturated(dp_sat)
   );

   // Load transfers return all-zero results.
   assign rsp_spline_value = load_rsp ? '0 : dp_value;
   assign rsp_outside      = load_rsp ? 1'b0 : dp_outside;
   assign rsp_saturated    = load_rsp ? 1'b0 : dp_sat;
endmodule
